// File: design/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame check and convert: shared definitions
// Field widths, result codes and register indexes used across the block.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int CAUSE_W   = 3;
  localparam int ATTEMPT_W = 4;
  localparam int TEMP_W    = 12;
  localparam int HUM_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_VALID    = 2'd0,
    STATUS_RETRY    = 2'd1,
    STATUS_FALLBACK = 2'd2
  } status_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_BUS      = 3'd1,
    CAUSE_TEMP_CRC = 3'd2,
    CAUSE_HUM_CRC  = 3'd3,
    CAUSE_RANGE    = 3'd4
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ATTEMPTS = 2'd0,
    CFG_FB_TEMP      = 2'd1,
    CFG_FB_HUM       = 2'd2
  } cfg_reg_t;

endpackage

// File: design/sfcc_if.sv
// ----------------------------------------------------------------------------
// Sensor frame check and convert: channel interfaces
// Valid/ready channels for received bytes and for decoded results.
// ----------------------------------------------------------------------------
interface sfcc_in_if;
  import sfcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   byte_value;
  logic                bus_error;

  modport source (output valid, output byte_value, output bus_error, input ready);
  modport sink   (input valid, input byte_value, input bus_error, output ready);
endinterface

interface sfcc_out_if;
  import sfcc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [CAUSE_W-1:0]         fail_cause;
  logic [ATTEMPT_W-1:0]       attempt_number;
  logic signed [TEMP_W-1:0]   temperature_tenths;
  logic [HUM_W-1:0]           humidity_percent;

  modport source (output valid, output status, output fail_cause, output attempt_number,
                  output temperature_tenths, output humidity_percent, input ready);
  modport sink   (input valid, input status, input fail_cause, input attempt_number,
                  input temperature_tenths, input humidity_percent, output ready);
endinterface

// File: design/sensor_frame_check_convert.sv
// ----------------------------------------------------------------------------
// Sensor frame check and convert
// Checks six-byte humidity/temperature frames with CRC-8 and converts good
// readings; reports retries and fallback values after repeated failures.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle on the input channel: a frame
// byte (temperature MSB, LSB, CRC, humidity MSB, LSB, CRC) or a bus error
// event. Each transfer is first captured in an input register; when it moves
// on, a single pass of logic updates the frame state (byte position, CRC
// accumulator, raw words, attempt count) and, when the transfer closes an
// attempt, loads a result into the output register. A result therefore passes
// through the input register and then the output register, where it is
// offered on the output channel until it is taken. A new byte is accepted
// every cycle for as long as the output side keeps up. The input stalls only
// when the output register holds a result that has not been taken and the
// captured byte cannot move on. Configuration writes take effect at the edge
// on which cfg_we is high and must be made while the block is idle.
module sensor_frame_check_convert (
  input  logic                               clk,
  input  logic                               rst_n,
  sfcc_in_if.sink                            in_chan,
  sfcc_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [sfcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfcc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sfcc_pkg::*;

  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam byte_t      CRC_INIT  = 8'hFF;
  localparam byte_t      CRC_POLY  = 8'h31;
  localparam word_t      WORD_ONES = 16'hFFFF;

  // MSB-first CRC-8 over one byte, no final inversion.
  function automatic byte_t crc8_byte(input byte_t crc_in, input byte_t data);
    byte_t c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Configuration registers.
  logic [ATTEMPT_W-1:0]     max_att_r;
  logic signed [TEMP_W-1:0] fb_temp_r;
  logic [HUM_W-1:0]         fb_hum_r;

  // Input register.
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_bus_err_r;

  // Frame state.
  logic [2:0]           pos_r,    pos_nxt;
  byte_t                crc_r,    crc_nxt;
  word_t                tword_r,  tword_nxt;
  word_t                hword_r,  hword_nxt;
  logic                 tbad_r,   tbad_nxt;
  logic [ATTEMPT_W-1:0] fails_r,  fails_nxt;

  // Output register.
  logic                     out_valid_r;
  status_t                  out_status_r, out_status_nxt;
  cause_t                   out_cause_r,  out_cause_nxt;
  logic [ATTEMPT_W-1:0]     out_att_r,    out_att_nxt;
  logic signed [TEMP_W-1:0] out_temp_r,   out_temp_nxt;
  logic [HUM_W-1:0]         out_hum_r,    out_hum_nxt;

  logic                     s1_adv;
  logic                     res_load;
  logic                     frame_end;
  logic                     fail;
  cause_t                   cause;
  logic [ATTEMPT_W-1:0]     attempt;
  logic signed [TEMP_W-1:0] conv_temp;
  logic [HUM_W-1:0]         conv_hum;

  // The captured transfer moves on whenever the output register is free or is
  // being emptied in this cycle; a new transfer can then be taken at once.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  sfcc_scale u_scale (
    .temp_word   (tword_r),
    .hum_word    (hword_r),
    .temp_tenths (conv_temp),
    .hum_percent (conv_hum)
  );

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    tword_nxt = tword_r;
    hword_nxt = hword_r;
    tbad_nxt  = tbad_r;
    fails_nxt = fails_r;
    frame_end = 1'b0;
    fail      = 1'b0;
    cause     = CAUSE_NONE;

    if (s1_bus_err_r) begin
      // A bus error closes the attempt at once and restarts the frame.
      pos_nxt  = POS_T_MSB;
      crc_nxt  = CRC_INIT;
      tbad_nxt = 1'b0;
      fail     = 1'b1;
      cause    = CAUSE_BUS;
    end else begin
      case (pos_r)
        POS_T_MSB, POS_T_LSB: begin
          tword_nxt = {tword_r[7:0], s1_byte_r};
          crc_nxt   = crc8_byte(crc_r, s1_byte_r);
          pos_nxt   = pos_r + 3'd1;
        end
        POS_T_CRC: begin
          tbad_nxt = (crc_r != s1_byte_r);
          crc_nxt  = CRC_INIT;
          pos_nxt  = POS_H_MSB;
        end
        POS_H_MSB, POS_H_LSB: begin
          hword_nxt = {hword_r[7:0], s1_byte_r};
          crc_nxt   = crc8_byte(crc_r, s1_byte_r);
          pos_nxt   = pos_r + 3'd1;
        end
        default: begin
          // Humidity CRC byte: the attempt ends here. The checks are taken
          // in priority order: temperature CRC, humidity CRC, raw range.
          frame_end = 1'b1;
          pos_nxt   = POS_T_MSB;
          crc_nxt   = CRC_INIT;
          tbad_nxt  = 1'b0;
          if (tbad_r) begin
            fail  = 1'b1;
            cause = CAUSE_TEMP_CRC;
          end else if (crc_r != s1_byte_r) begin
            fail  = 1'b1;
            cause = CAUSE_HUM_CRC;
          end else if (tword_r == '0 || tword_r == WORD_ONES ||
                       hword_r == '0 || hword_r == WORD_ONES) begin
            fail  = 1'b1;
            cause = CAUSE_RANGE;
          end
        end
      endcase
    end

    // Result selection. The attempt count wraps in four bits.
    attempt        = fails_r + 4'd1;
    out_att_nxt    = attempt;
    out_cause_nxt  = cause;
    out_status_nxt = STATUS_VALID;
    out_temp_nxt   = conv_temp;
    out_hum_nxt    = conv_hum;
    if (fail) begin
      if (attempt >= max_att_r) begin
        out_status_nxt = STATUS_FALLBACK;
        out_temp_nxt   = fb_temp_r;
        out_hum_nxt    = fb_hum_r;
        fails_nxt      = '0;
      end else begin
        out_status_nxt = STATUS_RETRY;
        out_temp_nxt   = '0;
        out_hum_nxt    = '0;
        fails_nxt      = attempt;
      end
    end else if (frame_end) begin
      fails_nxt = '0;
    end
  end

  assign res_load = s1_adv && (s1_bus_err_r || frame_end);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_att_r <= 4'd3;
      fb_temp_r <= 12'sd210;
      fb_hum_r  <= 7'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ATTEMPTS: max_att_r <= cfg_wdata[ATTEMPT_W-1:0];
        CFG_FB_TEMP:      fb_temp_r <= signed'(cfg_wdata[TEMP_W-1:0]);
        CFG_FB_HUM:       fb_hum_r  <= cfg_wdata[HUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r    <= in_chan.byte_value;
      s1_bus_err_r <= in_chan.bus_error;
    end
  end

  // Frame state, updated as each captured transfer moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_T_MSB;
      crc_r   <= CRC_INIT;
      tword_r <= '0;
      hword_r <= '0;
      tbad_r  <= 1'b0;
      fails_r <= '0;
    end else if (s1_adv) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      tword_r <= tword_nxt;
      hword_r <= hword_nxt;
      tbad_r  <= tbad_nxt;
      fails_r <= fails_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= out_status_nxt;
      out_cause_r  <= out_cause_nxt;
      out_att_r    <= out_att_nxt;
      out_temp_r   <= out_temp_nxt;
      out_hum_r    <= out_hum_nxt;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.status             = out_status_r;
  assign out_chan.fail_cause         = out_cause_r;
  assign out_chan.attempt_number     = out_att_r;
  assign out_chan.temperature_tenths = out_temp_r;
  assign out_chan.humidity_percent   = out_hum_r;

  // The byte position never leaves the six positions of a frame.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 3'd5)
    else $error("byte position beyond end of frame");

  // A good reading carries no cause; a failure always carries one.
  a_cause_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_status_r == STATUS_VALID) == (out_cause_r == CAUSE_NONE)))
    else $error("fail cause does not match result status");

  // A retry result reports zero readings.
  a_retry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_RETRY) |-> (out_temp_r == '0 && out_hum_r == '0))
    else $error("retry result with non-zero readings");

  // Any result other than a retry leaves the attempt count cleared.
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && out_status_nxt != STATUS_RETRY) |=> (fails_r == '0))
    else $error("attempt count not cleared after closing result");

endmodule

// File: design/sfcc_scale.sv
// ----------------------------------------------------------------------------
// Sensor frame check and convert: raw word scaling
// Converts raw temperature and humidity words to tenths of a degree and
// whole percent with exact rounding, using constant multiplies and adds only.
// ----------------------------------------------------------------------------
module sfcc_scale (
  input  sfcc_pkg::word_t                        temp_word,
  input  sfcc_pkg::word_t                        hum_word,
  output logic signed [sfcc_pkg::TEMP_W-1:0]     temp_tenths,
  output logic        [sfcc_pkg::HUM_W-1:0]      hum_percent
);
  import sfcc_pkg::*;

  localparam logic [10:0] TEMP_SPAN   = 11'd1750;
  localparam logic [6:0]  HUM_SPAN    = 7'd100;
  localparam logic [15:0] HALF_DIV    = 16'd32767;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 12'd450;

  // Rounded quotient by 65535 is floor((n + 32767) / 65535). With
  // m = a*65536 + b the quotient is a, plus one when a + b + 1 carries
  // out of sixteen bits.
  logic [27:0] t_sum;
  logic [11:0] t_hi;
  logic [16:0] t_carry;
  logic [10:0] t_q;
  logic [23:0] h_sum;
  logic [7:0]  h_hi;
  logic [16:0] h_carry;
  logic [6:0]  h_q;

  always_comb begin
    t_sum   = 28'(temp_word) * 28'(TEMP_SPAN) + 28'(HALF_DIV);
    t_hi    = t_sum[27:16];
    t_carry = 17'(t_hi) + 17'(t_sum[15:0]) + 17'd1;
    t_q     = 11'(t_hi + 12'(t_carry[16]));

    h_sum   = 24'(hum_word) * 24'(HUM_SPAN) + 24'(HALF_DIV);
    h_hi    = h_sum[23:16];
    h_carry = 17'(h_hi) + 17'(h_sum[15:0]) + 17'd1;
    h_q     = 7'(h_hi + 8'(h_carry[16]));

    temp_tenths = signed'({1'b0, t_q} - TEMP_OFFSET);
    hum_percent = h_q;
  end

endmodule
